>>> hw/rtl/cls_pkg.sv
package cls_pkg;

   localparam int VALUE_W = 16;
   localparam int LIMB_W  = 16;
   localparam int FRAC_W  = 16;
   localparam int SOL_W   = 32;
   localparam int IDX_W   = 2;
   localparam int NACT_W  = 3;
   localparam logic [NACT_W-1:0] NACT_RESET = 3'd3;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_TRY   = 7'b0000010,
      S_MUL   = 7'b0000100,
      S_ACC   = 7'b0001000,
      S_DDONE = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_EMIT  = 7'b1000000
   } cls_state_type;

endpackage

>>> hw/rtl/cramer_linear_system_solver_unit.sv
// Loading: one word per cycle while busy is low; N*(N+1) words per system.
// Solve: N+1 determinants by depth-first permutation walk (only the first if it
// is zero), each product step one 16x16 limb multiply per cycle over MAX_UNKNOWNS+1
// limbs, then N restoring divisions; busy stays high the whole time.
// Results leave one per strobe cycle; the receiver cannot stall them.
// Synchronous active-high reset clears control state and sets n_active to 3.
module cramer_linear_system_solver_unit import cls_pkg::*; #(
   parameter int MAX_UNKNOWNS = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [NACT_W-1:0]        csr_n_active,
   output logic                     rsp_valid,
   output logic [IDX_W-1:0]         rsp_solution_index,
   output logic signed [SOL_W-1:0]  rsp_solution,
   output logic                     rsp_singular,
   output logic                     rsp_last
);

   localparam int DEPTH = MAX_UNKNOWNS * (MAX_UNKNOWNS + 1);
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = $clog2(DEPTH + 1);
   localparam int CW    = $clog2(MAX_UNKNOWNS + 1);
   localparam int NL    = MAX_UNKNOWNS + 1;
   localparam int MW    = LIMB_W * NL;
   localparam int DW    = MW + 12;
   localparam int NW    = DW + FRAC_W;
   localparam int QCW   = $clog2(NW + 1);

   logic [NACT_W-1:0]        n_active_ff, n_active_in;
   logic [LW-1:0]            load_count_ff, load_count_in;
   logic signed [VALUE_W-1:0] store_ff [DEPTH];
   cls_state_type            state_ff, state_in;
   logic [CW-1:0]            lvl_ff, lvl_in, cand_ff, cand_in, repl_ff, repl_in;
   logic [CW-1:0]            limb_ff, limb_in;
   logic [CW-1:0]            col_ff [NL];
   logic [NL-1:0]            used_ff, used_in;
   logic [MW-1:0]            prod_ff [NL];
   logic                     psgn_ff [NL];
   logic [LIMB_W-1:0]        ent_mag_ff, ent_mag_in, carry_ff, carry_in;
   logic [DW-1:0]            acc_ff, acc_in, dmag_ff, dmag_in, rem_ff, rem_in;
   logic                     dneg_ff, dneg_in, qneg_ff, qneg_in;
   logic [NW-1:0]            quo_ff, quo_in;
   logic [QCW-1:0]           dcnt_ff, dcnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [SOL_W-1:0]         rsp_solution_ff, rsp_solution_in;
   logic                     rsp_singular_ff, rsp_singular_in, rsp_last_ff, rsp_last_in;

   logic [CW-1:0]            n_eff, sel_col, lvl_up, lvl_dn;
   logic [AW-1:0]            rd_addr;
   logic signed [VALUE_W-1:0] rd_val;
   logic                     inv_par, psgn_cur, take, mul_wr, load_wr;
   logic [LIMB_W-1:0]        cur_limb;
   logic [2*LIMB_W-1:0]      mul_res;
   logic [DW-1:0]            leaf_ext, amag;
   logic [DW:0]              r2;
   logic                     ge, big;

   always_comb begin
      if (n_active_ff == '0) n_eff = CW'(1);
      else if (int'(n_active_ff) > MAX_UNKNOWNS) n_eff = CW'(MAX_UNKNOWNS);
      else n_eff = CW'(n_active_ff);
   end

   assign lvl_up   = CW'(lvl_ff + 1'b1);
   assign lvl_dn   = CW'(lvl_ff - 1'b1);
   assign sel_col  = (cand_ff == repl_ff) ? n_eff : cand_ff;
   assign rd_addr  = AW'(int'(lvl_ff) * (int'(n_eff) + 1) + int'(sel_col));
   assign rd_val   = store_ff[rd_addr];
   assign psgn_cur = (lvl_ff == '0) ? 1'b0 : psgn_ff[lvl_ff];

   // parity of inversions added by placing cand after the columns already used
   always_comb begin
      inv_par = 1'b0;
      for (int j = 0; j < NL; j++) begin
         if (used_ff[j] && (CW'(j) > cand_ff)) inv_par = ~inv_par;
      end
   end

   always_comb begin
      if (lvl_ff == '0) cur_limb = (limb_ff == '0) ? LIMB_W'(1) : '0;
      else cur_limb = prod_ff[lvl_ff][limb_ff*LIMB_W +: LIMB_W];
   end

   assign mul_res  = {{LIMB_W{1'b0}}, cur_limb} * {{LIMB_W{1'b0}}, ent_mag_ff}
                   + {{LIMB_W{1'b0}}, carry_ff};
   assign leaf_ext = DW'(prod_ff[lvl_ff]);
   assign amag     = acc_ff[DW-1] ? DW'(-acc_ff) : acc_ff;
   assign r2       = {rem_ff, quo_ff[NW-1]};
   assign ge       = r2 >= {1'b0, dmag_ff};
   assign big      = |quo_ff[NW-1:SOL_W];

   always_comb begin
      n_active_in     = n_active_ff;
      load_count_in   = load_count_ff;
      state_in        = state_ff;
      lvl_in          = lvl_ff;
      cand_in         = cand_ff;
      repl_in         = repl_ff;
      limb_in         = limb_ff;
      used_in         = used_ff;
      ent_mag_in      = ent_mag_ff;
      carry_in        = carry_ff;
      acc_in          = acc_ff;
      dmag_in         = dmag_ff;
      dneg_in         = dneg_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      qneg_in         = qneg_ff;
      dcnt_in         = dcnt_ff;
      rsp_valid_in    = 1'b0;
      rsp_index_in    = rsp_index_ff;
      rsp_solution_in = rsp_solution_ff;
      rsp_singular_in = rsp_singular_ff;
      rsp_last_in     = rsp_last_ff;
      take            = 1'b0;
      mul_wr          = 1'b0;
      load_wr         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               load_wr = 1'b1;
               if (int'(load_count_ff) + 1 == int'(n_eff) * (int'(n_eff) + 1)) begin
                  load_count_in = '0;
                  repl_in       = n_eff;
                  lvl_in        = '0;
                  cand_in       = '0;
                  used_in       = '0;
                  acc_in        = '0;
                  state_in      = S_TRY;
               end else begin
                  load_count_in = LW'(load_count_ff + 1'b1);
               end
            end
         end
         S_TRY: begin
            if (lvl_ff == n_eff) begin
               state_in = S_ACC;
            end else if (cand_ff == n_eff) begin
               if (lvl_ff == '0) begin
                  state_in = S_DDONE;
               end else begin
                  lvl_in               = lvl_dn;
                  cand_in              = CW'(col_ff[lvl_dn] + 1'b1);
                  used_in[col_ff[lvl_dn]] = 1'b0;
               end
            end else if (used_ff[cand_ff]) begin
               cand_in = CW'(cand_ff + 1'b1);
            end else begin
               take             = 1'b1;
               used_in[cand_ff] = 1'b1;
               ent_mag_in       = rd_val[VALUE_W-1] ? LIMB_W'(-rd_val) : LIMB_W'(rd_val);
               limb_in          = '0;
               carry_in         = '0;
               state_in         = S_MUL;
            end
         end
         S_MUL: begin
            mul_wr   = 1'b1;
            carry_in = mul_res[2*LIMB_W-1:LIMB_W];
            limb_in  = CW'(limb_ff + 1'b1);
            if (int'(limb_ff) == NL - 1) begin
               lvl_in   = lvl_up;
               cand_in  = '0;
               state_in = S_TRY;
            end
         end
         S_ACC: begin
            acc_in                  = psgn_ff[lvl_ff] ? DW'(acc_ff - leaf_ext)
                                                      : DW'(acc_ff + leaf_ext);
            lvl_in                  = lvl_dn;
            cand_in                 = CW'(col_ff[lvl_dn] + 1'b1);
            used_in[col_ff[lvl_dn]] = 1'b0;
            state_in                = S_TRY;
         end
         S_DDONE: begin
            if (repl_ff == n_eff) begin
               if (acc_ff == '0) begin
                  rsp_valid_in    = 1'b1;
                  rsp_index_in    = '0;
                  rsp_solution_in = '0;
                  rsp_singular_in = 1'b1;
                  rsp_last_in     = 1'b1;
                  state_in        = S_IDLE;
               end else begin
                  dmag_in  = amag;
                  dneg_in  = acc_ff[DW-1];
                  repl_in  = '0;
                  lvl_in   = '0;
                  cand_in  = '0;
                  used_in  = '0;
                  acc_in   = '0;
                  state_in = S_TRY;
               end
            end else begin
               quo_in   = {amag, {FRAC_W{1'b0}}};
               rem_in   = '0;
               qneg_in  = acc_ff[DW-1] ^ dneg_ff;
               dcnt_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = ge ? DW'(r2 - {1'b0, dmag_ff}) : r2[DW-1:0];
            quo_in  = {quo_ff[NW-2:0], ge};
            dcnt_in = QCW'(dcnt_ff + 1'b1);
            if (int'(dcnt_ff) == NW - 1) state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_valid_in    = 1'b1;
            rsp_index_in    = IDX_W'(repl_ff);
            rsp_singular_in = 1'b0;
            rsp_last_in     = (CW'(repl_ff + 1'b1) == n_eff);
            if (qneg_ff) begin
               if (big || quo_ff[SOL_W-1:0] > 32'h8000_0000) rsp_solution_in = 32'h8000_0000;
               else rsp_solution_in = -quo_ff[SOL_W-1:0];
            end else begin
               if (big || quo_ff[SOL_W-1]) rsp_solution_in = 32'h7FFF_FFFF;
               else rsp_solution_in = quo_ff[SOL_W-1:0];
            end
            if (CW'(repl_ff + 1'b1) == n_eff) begin
               state_in = S_IDLE;
            end else begin
               repl_in  = CW'(repl_ff + 1'b1);
               lvl_in   = '0;
               cand_in  = '0;
               used_in  = '0;
               acc_in   = '0;
               state_in = S_TRY;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_valid && csr_ready) begin
         n_active_in   = csr_n_active;
         load_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         n_active_ff   <= NACT_RESET;
         load_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         n_active_ff   <= n_active_in;
         load_count_ff <= load_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff          <= lvl_in;
      cand_ff         <= cand_in;
      repl_ff         <= repl_in;
      limb_ff         <= limb_in;
      used_ff         <= used_in;
      ent_mag_ff      <= ent_mag_in;
      carry_ff        <= carry_in;
      acc_ff          <= acc_in;
      dmag_ff         <= dmag_in;
      dneg_ff         <= dneg_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      qneg_ff         <= qneg_in;
      dcnt_ff         <= dcnt_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_solution_ff <= rsp_solution_in;
      rsp_singular_ff <= rsp_singular_in;
      rsp_last_ff     <= rsp_last_in;
      if (load_wr) store_ff[load_count_ff[AW-1:0]] <= req_value;
      if (take) begin
         col_ff[lvl_ff]  <= cand_ff;
         psgn_ff[lvl_up] <= psgn_cur ^ rd_val[VALUE_W-1] ^ inv_par;
      end
      if (mul_wr) prod_ff[lvl_up][limb_ff*LIMB_W +: LIMB_W] <= mul_res[LIMB_W-1:0];
   end

   assign busy               = (state_ff != S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_solution_index = rsp_index_ff;
   assign rsp_solution       = rsp_solution_ff;
   assign rsp_singular       = rsp_singular_ff;
   assign rsp_last           = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_singular_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_singular_ff |-> rsp_last_ff && rsp_index_ff == '0)
      else $error("singular word not final");
   a_mul_depth: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> lvl_ff < n_eff)
      else $error("product walk beyond matrix size");
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("solve began without a loaded word");
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> int'(dcnt_ff) < NW)
      else $error("division ran past quotient width");
`endif

endmodule
